/* sv/isuo_pkg.sv */
// Shared types and constants for the interval stabbing unique-owner block.
package isuo_pkg;

  localparam int POS_W    = 11;
  localparam int OWNER_W  = 16;
  localparam int STATUS_W = 2;
  localparam int TAG_W    = 2;

  localparam logic [POS_W-1:0] LEAF_COUNT_RST = 11'd1024;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OWNER = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MULTI = 2'd2;

  // Operation codes carried by an input beat
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [TAG_W-1:0] {
    TAG_UNVISITED = 2'd0,
    TAG_OWNER     = 2'd1,
    TAG_MULTIPLE  = 2'd2,
    TAG_SPLIT     = 2'd3
  } tag_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_WALK  = 2'd2
  } state_e;

endpackage

/* sv/isuo_ifs.sv */
// Valid/ready channel interfaces for input items and query results.
interface isuo_in_if import isuo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [POS_W-1:0]   range_low;
  logic [POS_W-1:0]   range_high;
  logic [OWNER_W-1:0] owner_id;
  logic [POS_W-1:0]   point;

  modport source (output valid, output op, output range_low, output range_high,
                  output owner_id, output point, input ready);
  modport sink   (input valid, input op, input range_low, input range_high,
                  input owner_id, input point, output ready);
endinterface

interface isuo_out_if import isuo_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OWNER_W-1:0]  found_id;

  modport source (output valid, output status, output found_id, input ready);
  modport sink   (input valid, input status, input found_id, output ready);
endinterface

/* sv/isuo_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
module isuo_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/interval_stabbing_unique_owner_core.sv */
// Top level: segment tree of interval owners with point queries, walked one node a cycle.
//
//  channel    | dir | handshake          | payload
//  -----------+-----+--------------------+----------------------------------------------
//  item_i     | in  | valid/ready        | op, range_low, range_high, owner_id, point
//  result_o   | out | valid/ready        | status, found_id (one beat per query)
//  cfg        | in  | cfg_we_i, no stall | cfg_wdata_i = leaf_count
//
// An item is accepted, then walks the tree node by node: a query visits at most one node
// per level, an insert also descends through every split node inside its range, up to
// 2*leaf_count-1 nodes. After reset a clearing pass writes all 4*LEAVES nodes (4096 at
// the default) unvisited, with item_i.ready low. A result waits in an output register; a
// query that finishes while that register is still full holds its last node until it
// drains.
module interval_stabbing_unique_owner_core import isuo_pkg::*; #(
  parameter int LEAVES  = 1024,
  parameter int ID_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [POS_W-1:0] cfg_wdata_i,
  isuo_in_if.sink          item_i,
  isuo_out_if.source       result_o
);

  localparam int NODES       = 4 * LEAVES;
  localparam int NODE_AW     = $clog2(NODES);
  localparam int NODE_W      = TAG_W + ID_BITS;
  localparam int STACK_DEPTH = $clog2(LEAVES) + 1;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W      = $clog2(STACK_DEPTH);
  localparam int ID_IN_W     = (ID_BITS < OWNER_W) ? ID_BITS : OWNER_W;

  // One pending node visit: address, covered positions and the owner pushed from above
  typedef struct packed {
    logic [NODE_AW-1:0] node;
    logic [POS_W-1:0]   lo;
    logic [POS_W-1:0]   hi;
    logic               push;
    logic [ID_BITS-1:0] push_id;
  } frame_t;

  state_e              state_q, state_d;
  logic [POS_W-1:0]    leaf_q;
  logic [NODE_AW-1:0]  clr_q, clr_d;
  frame_t              cur_q, cur_d;
  logic [SP_W-1:0]     sp_q, sp_d;
  frame_t              stack_q [STACK_DEPTH];
  logic                stack_we;
  frame_t              stack_wdata;
  logic                op_q;
  logic [POS_W-1:0]    lo_q, hi_q, pt_q;
  logic [ID_BITS-1:0]  id_q;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [OWNER_W-1:0]  out_id_q, out_id_d;

  logic                ram_we;
  logic [NODE_AW-1:0]  ram_waddr, ram_raddr;
  logic [NODE_W-1:0]   ram_wdata, ram_rdata;

  logic                in_acc;
  logic [POS_W-1:0]    act_leaves;
  logic [SP_W-1:0]     sp_m1;
  frame_t              stack_top;

  tag_e                rd_tag, eff_tag, lvl_tag, wr_tag;
  logic [ID_BITS-1:0]  rd_id, eff_id, wr_id;
  logic                is_leaf, pushed, hit, covered;
  logic [POS_W:0]      mid_sum;
  logic [POS_W-1:0]    mid;
  logic [NODE_AW-1:0]  left_node, right_node;
  logic                ins_wr, ins_descend, child_push;
  logic                q_done, q_left, out_free;
  logic [STATUS_W-1:0] res_status;
  logic [OWNER_W-1:0]  res_id;

  assign in_acc    = item_i.valid && item_i.ready;
  assign sp_m1     = sp_q - 1'b1;
  assign stack_top = stack_q[sp_m1[SIDX_W-1:0]];
  assign out_free  = !out_valid_q || result_o.ready;

  // Clamp the configured leaf count into 1..LEAVES
  always_comb begin
    if (leaf_q == '0) begin
      act_leaves = POS_W'(1);
    end else if (32'(leaf_q) > LEAVES) begin
      act_leaves = POS_W'(LEAVES);
    end else begin
      act_leaves = leaf_q;
    end
  end

  // Evaluate the node just read against the current item
  always_comb begin
    rd_tag     = tag_e'(ram_rdata[NODE_W-1 -: TAG_W]);
    rd_id      = ram_rdata[ID_BITS-1:0];
    is_leaf    = (cur_q.lo == cur_q.hi);
    mid_sum    = {1'b0, cur_q.lo} + {1'b0, cur_q.hi};
    mid        = mid_sum[POS_W:1];
    left_node  = NODE_AW'({cur_q.node, 1'b0} + 2'd1);
    right_node = NODE_AW'({cur_q.node, 1'b0} + 2'd2);

    // Inherit the parent's owner if this node was never touched
    pushed  = cur_q.push && (rd_tag == TAG_UNVISITED);
    eff_tag = pushed ? TAG_OWNER : rd_tag;
    eff_id  = pushed ? cur_q.push_id : rd_id;
    hit     = !((hi_q < cur_q.lo) || (lo_q > cur_q.hi) || (lo_q > hi_q));
    covered = (lo_q <= cur_q.lo) && (cur_q.hi <= hi_q);
    // A leaf left split by an older tree shape counts as unvisited
    lvl_tag = (is_leaf && (eff_tag == TAG_SPLIT)) ? TAG_UNVISITED : eff_tag;

    ins_wr      = 1'b0;
    ins_descend = 1'b0;
    wr_tag      = eff_tag;
    wr_id       = eff_id;
    priority if (!hit) begin
      ins_wr = pushed;
    end else if (eff_tag == TAG_MULTIPLE) begin
      ins_wr = 1'b0;
    end else if ((lvl_tag != TAG_SPLIT) && covered) begin
      ins_wr = 1'b1;
      if (lvl_tag == TAG_UNVISITED) begin
        wr_tag = TAG_OWNER;
        wr_id  = id_q;
      end else begin
        wr_tag = TAG_MULTIPLE;
        wr_id  = '0;
      end
    end else if (is_leaf) begin
      ins_wr = 1'b1;
      wr_tag = lvl_tag;
    end else begin
      ins_wr      = 1'b1;
      ins_descend = 1'b1;
      wr_tag      = TAG_SPLIT;
      wr_id       = '0;
    end
    child_push = (lvl_tag == TAG_OWNER);

    // Query: stop at the first node that is not split
    q_done = (rd_tag != TAG_SPLIT) || is_leaf;
    q_left = (pt_q <= mid);
    unique case (rd_tag)
      TAG_OWNER: begin
        res_status = STAT_OWNER;
        res_id     = OWNER_W'(rd_id[ID_IN_W-1:0]);
      end
      TAG_MULTIPLE: begin
        res_status = STAT_MULTI;
        res_id     = '0;
      end
      default: begin
        res_status = STAT_NONE;
        res_id     = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == NODE_AW'(NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (op_q == OP_INSERT) begin
          if (!ins_descend && (sp_q == '0)) begin
            state_d = ST_IDLE;
          end
        end else if (q_done && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    item_i.ready = (state_q == ST_IDLE);
    ram_we       = 1'b0;
    ram_waddr    = cur_q.node;
    ram_wdata    = {wr_tag, wr_id};
    ram_raddr    = cur_q.node;
    cur_d        = cur_q;
    sp_d         = sp_q;
    clr_d        = clr_q;
    stack_we     = 1'b0;
    stack_wdata  = '{node: right_node, lo: mid + 1'b1, hi: cur_q.hi,
                     push: child_push, push_id: eff_id};
    out_valid_d  = out_valid_q && !result_o.ready;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        // Start every walk at the root
        ram_raddr = '0;
        if (in_acc) begin
          cur_d = '{node: '0, lo: POS_W'(1), hi: act_leaves, push: 1'b0, push_id: '0};
          sp_d  = '0;
        end
      end
      ST_WALK: begin
        if (op_q == OP_INSERT) begin
          ram_we = ins_wr;
          if (ins_descend) begin
            // Park the right child, descend left
            stack_we  = 1'b1;
            sp_d      = sp_q + 1'b1;
            cur_d     = '{node: left_node, lo: cur_q.lo, hi: mid,
                          push: child_push, push_id: eff_id};
            ram_raddr = left_node;
          end else if (sp_q != '0) begin
            // Resume the most recent parked sibling
            cur_d     = stack_top;
            sp_d      = sp_m1;
            ram_raddr = stack_top.node;
          end
        end else if (q_done) begin
          // Hold the node until the result register can take the beat
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = res_status;
            out_id_d     = res_id;
          end
        end else if (q_left) begin
          cur_d     = '{node: left_node, lo: cur_q.lo, hi: mid, push: 1'b0, push_id: '0};
          ram_raddr = left_node;
        end else begin
          cur_d     = '{node: right_node, lo: mid + 1'b1, hi: cur_q.hi,
                        push: 1'b0, push_id: '0};
          ram_raddr = right_node;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.status   = out_status_q;
  assign result_o.found_id = out_id_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      leaf_q      <= LEAF_COUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        leaf_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    if (stack_we) begin
      stack_q[sp_q[SIDX_W-1:0]] <= stack_wdata;
    end
    if (in_acc) begin
      op_q <= item_i.op;
      lo_q <= item_i.range_low;
      hi_q <= item_i.range_high;
      id_q <= ID_BITS'(item_i.owner_id[ID_IN_W-1:0]);
      pt_q <= item_i.point;
    end
  end

  isuo_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES)
  ) u_node_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Parked siblings never exceed the tree height
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("sibling stack overflow");

  // Every walk leaves the stack empty
  a_idle_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (sp_q == '0))
    else $error("stack not empty between items");

  // The node store is only written while clearing or walking
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("node store written while idle");

  // A result beat only follows a query walk
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past((state_q == ST_WALK) && (op_q == OP_QUERY)))
    else $error("result raised outside a query");

  // Only a single owner reports an id
  a_id_only_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.status != STAT_OWNER)) |-> (result_o.found_id == '0))
    else $error("id reported without a single owner");

endmodule

/* tb/isuo_owner_checker.sv */
// Checker for the owner tree: mirrors the node store, predicts query beats and compares them.
module isuo_owner_checker import isuo_pkg::*; #(
  parameter int LEAVES  = 1024,
  parameter int ID_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [POS_W-1:0] cfg_wdata_i,
  isuo_in_if               item_mon,
  isuo_out_if              result_mon,
  output int               errors_o,
  output int               owed_o,
  output int               checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 4 * LEAVES;
  localparam logic [OWNER_W-1:0] ID_MASK =
    (ID_BITS >= OWNER_W) ? {OWNER_W{1'b1}} : OWNER_W'((64'd1 << ID_BITS) - 64'd1);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OWNER_W-1:0]  found_id;
  } query_result_t;

  tag_e               tag_mem [NODES];
  logic [OWNER_W-1:0] id_mem  [NODES];
  logic [POS_W-1:0]   leaf_count_q;
  query_result_t      owed_results [$];

  // Clamp the leaf count to the shape the tree is walked with
  function automatic int unsigned tree_span();
    int unsigned m;
    m = leaf_count_q;
    if (m == 0) m = 1;
    if (m > LEAVES) m = LEAVES;
    return m;
  endfunction

  // Add [cl, cr] with owner id; walk with an explicit stack, siblings are independent
  function automatic void tree_insert(int unsigned cl, int unsigned cr,
                                      logic [OWNER_W-1:0] id);
    int unsigned stk_n [$];
    int unsigned stk_l [$];
    int unsigned stk_r [$];
    int unsigned n, l, r, mid, a, b;
    stk_n.push_back(0);
    stk_l.push_back(1);
    stk_r.push_back(tree_span());
    while (stk_n.size() > 0) begin
      n = stk_n.pop_back();
      l = stk_l.pop_back();
      r = stk_r.pop_back();
      if (n >= NODES) continue;
      if (cr < l || cl > r || cl > cr) continue;
      if (tag_mem[n] == TAG_MULTIPLE) continue;
      // a split leaf left over from another shape reads as unvisited
      if (l == r && tag_mem[n] == TAG_SPLIT) tag_mem[n] = TAG_UNVISITED;
      if (tag_mem[n] != TAG_SPLIT && cl <= l && r <= cr) begin
        if (tag_mem[n] == TAG_UNVISITED) begin
          tag_mem[n] = TAG_OWNER;
          id_mem[n]  = id;
        end else begin
          tag_mem[n] = TAG_MULTIPLE;
          id_mem[n]  = '0;
        end
        continue;
      end
      if (l == r) continue;
      a = 2 * n + 1;
      b = 2 * n + 2;
      if (b >= NODES) continue;
      // push the node's tag into unvisited children before descending
      if (tag_mem[n] != TAG_SPLIT) begin
        if (tag_mem[a] == TAG_UNVISITED) begin
          tag_mem[a] = tag_mem[n];
          id_mem[a]  = id_mem[n];
        end
        if (tag_mem[b] == TAG_UNVISITED) begin
          tag_mem[b] = tag_mem[n];
          id_mem[b]  = id_mem[n];
        end
      end
      tag_mem[n] = TAG_SPLIT;
      id_mem[n]  = '0;
      mid = (l + r) / 2;
      stk_n.push_back(b);
      stk_l.push_back(mid + 1);
      stk_r.push_back(r);
      stk_n.push_back(a);
      stk_l.push_back(l);
      stk_r.push_back(mid);
    end
  endfunction

  // Walk toward the point and report the first node that is not split
  function automatic query_result_t tree_lookup(int unsigned q);
    int unsigned        n, l, r, mid;
    tag_e               t;
    logic [OWNER_W-1:0] v;
    query_result_t      res;
    n = 0;
    l = 1;
    r = tree_span();
    t = TAG_UNVISITED;
    v = '0;
    while (n < NODES) begin
      if (tag_mem[n] != TAG_SPLIT) begin
        t = tag_mem[n];
        v = id_mem[n];
        break;
      end
      if (l == r) break;
      mid = (l + r) / 2;
      if (q <= mid) begin
        n = 2 * n + 1;
        r = mid;
      end else begin
        n = 2 * n + 2;
        l = mid + 1;
      end
    end
    case (t)
      TAG_OWNER: begin
        res.status   = STAT_OWNER;
        res.found_id = v;
      end
      TAG_MULTIPLE: begin
        res.status   = STAT_MULTI;
        res.found_id = '0;
      end
      default: begin
        res.status   = STAT_NONE;
        res.found_id = '0;
      end
    endcase
    return res;
  endfunction

  // Compare result beats, then fold accepted items and register writes into the mirror
  always @(posedge clk_i or negedge rst_ni) begin
    query_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        tag_mem[i] = TAG_UNVISITED;
        id_mem[i]  = '0;
      end
      leaf_count_q = LEAF_COUNT_RST;
      owed_results.delete();
      errors_o  = 0;
      owed_o    = 0;
      checked_o = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t unexpected result beat: status %0d found_id %h", $time,
                   result_mon.status, result_mon.found_id);
          errors_o++;
        end else begin
          want = owed_results.pop_front();
          checked_o++;
          if (result_mon.status !== want.status) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time,
                     want.status, result_mon.status);
            errors_o++;
          end
          if (result_mon.found_id !== want.found_id) begin
            $display("%0t found_id mismatch: expected %h actual %h", $time,
                     want.found_id, result_mon.found_id);
            errors_o++;
          end
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        if (item_mon.op == OP_INSERT)
          tree_insert(item_mon.range_low, item_mon.range_high, item_mon.owner_id & ID_MASK);
        else
          owed_results.push_back(tree_lookup(item_mon.point));
      end
      if (cfg_we_i) leaf_count_q = cfg_wdata_i;
      owed_o = owed_results.size();
    end
  end

endmodule

/* tb/interval_stabbing_unique_owner_core_test.sv */
// Testbench top: drives items and leaf-count writes into the owner tree and gives the verdict.
module interval_stabbing_unique_owner_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import isuo_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int TREE_LEAVES   = 1024;
  localparam int ID_W          = 16;
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 175;
  localparam int POS_MAX       = (1 << POS_W) - 1;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [POS_W-1:0] cfg_wdata;

  isuo_in_if  item_bus ();
  isuo_out_if result_bus ();

  int fail_count;
  int owed_count;
  int beat_count;
  int gap_pct;
  int stall_pct;
  int idle_cycles;
  int n_inserts;
  int n_queries;
  int n_settings;

  // Leaf counts visited in order; a count of one lets a single insert reclaim the root
  int unsigned leaf_plan [PHASES] = '{1024, 1000, 700, 2047, 37, 3, 2, 1, 0, 513, 1024};

  interval_stabbing_unique_owner_core #(
    .LEAVES  (TREE_LEAVES),
    .ID_BITS (ID_W)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_bus),
    .result_o    (result_bus)
  );

  isuo_owner_checker #(
    .LEAVES  (TREE_LEAVES),
    .ID_BITS (ID_W)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_mon    (item_bus),
    .result_mon  (result_bus),
    .errors_o    (fail_count),
    .owed_o      (owed_count),
    .checked_o   (beat_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Stall the result channel at the current rate
  always @(posedge clk_i) begin
    result_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when nothing has been accepted for too long
  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item, after a random gap, and hold it until accepted
  task automatic push_item(input logic op, input logic [POS_W-1:0] lo,
                           input logic [POS_W-1:0] hi, input logic [OWNER_W-1:0] id,
                           input logic [POS_W-1:0] pt);
    if ($urandom_range(99) < gap_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
    end
    item_bus.valid      <= 1'b1;
    item_bus.op         <= op;
    item_bus.range_low  <= lo;
    item_bus.range_high <= hi;
    item_bus.owner_id   <= id;
    item_bus.point      <= pt;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    if (op == OP_INSERT) n_inserts++;
    else n_queries++;
  endtask

  // Mostly queries and narrow inserts, so the tree does not saturate to multiple too soon
  task automatic push_random_item(input int unsigned span);
    int unsigned kind, lo, hi, pt, w;
    logic [OWNER_W-1:0] id;
    lo   = $urandom_range(POS_MAX);
    hi   = $urandom_range(POS_MAX);
    pt   = $urandom_range(POS_MAX);
    id   = OWNER_W'($urandom());
    kind = $urandom_range(99);
    if (kind < 60) begin
      kind = $urandom_range(99);
      if (kind < 88) pt = $urandom_range(span, 1);
      else if (kind < 92) pt = 0;
      else if (kind < 96) pt = span;
      push_item(OP_QUERY, POS_W'(lo), POS_W'(hi), id, POS_W'(pt));
    end else begin
      kind = $urandom_range(99);
      if (kind < 94) begin
        if (kind < 72) w = $urandom_range(4, 1);
        else if (kind < 90) w = $urandom_range(span / 8 + 1, 1);
        else w = $urandom_range(span, 1);
        lo = $urandom_range(span, 1);
        hi = lo + w - 1;
      end else if (kind < 97) begin
        // empty interval: high below low
        hi = $urandom_range(span, 1);
        lo = hi + $urandom_range(40, 1);
      end else if (kind < 99) begin
        // starts below the tree
        lo = $urandom_range(2, 0);
        hi = lo + $urandom_range(3, 0);
      end else begin
        // runs past the top of the tree
        lo = (span > 3) ? span - $urandom_range(3, 0) : span;
        hi = $urandom_range(POS_MAX, span);
      end
      if (lo > POS_MAX) lo = POS_MAX;
      if (hi > POS_MAX) hi = POS_MAX;
      push_item(OP_INSERT, POS_W'(lo), POS_W'(hi), id, POS_W'(pt));
    end
  endtask

  // Drop valid and wait until every owed result beat has come back
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
  endtask

  // Drain, then wait for a trailing insert to finish its walk
  task automatic quiesce();
    drain_results();
    while (!item_bus.ready) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_leaf_count(input logic [POS_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  initial begin
    int unsigned span;
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    item_bus.valid      = 1'b0;
    item_bus.op         = OP_INSERT;
    item_bus.range_low  = '0;
    item_bus.range_high = '0;
    item_bus.owner_id   = '0;
    item_bus.point      = '0;
    result_bus.ready    = 1'b0;
    gap_pct             = 0;
    stall_pct           = 0;
    idle_cycles         = 0;
    n_inserts           = 0;
    n_queries           = 0;
    n_settings          = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset leaf count, confined to the low end plus the top edge
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd0);
    push_item(OP_INSERT, 11'd1,    11'd8,    16'h0000, 11'd0);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd8);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd9);
    push_item(OP_INSERT, 11'd9,    11'd16,   16'hFFFF, 11'd0);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd16);
    push_item(OP_INSERT, 11'd40,   11'd30,   16'h1234, 11'd0);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd30);
    push_item(OP_INSERT, 11'd1020, 11'd2047, 16'h5555, 11'd0);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd2047);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd1019);
    push_item(OP_INSERT, 11'd0,    11'd2,    16'h2AAA, 11'd0);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd1);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd3);
    push_item(OP_INSERT, 11'd8,    11'd9,    16'h0F0F, 11'd0);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd9);
    push_item(OP_INSERT, 11'd20,   11'd23,   16'hA5A5, 11'd0);
    push_item(OP_INSERT, 11'd22,   11'd25,   16'h5A5A, 11'd0);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd21);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd23);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd25);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd1024);
    push_item(OP_QUERY,  11'd0,    11'd0,    16'h0000, 11'd1500);

    // Random phases, each with its own leaf count and idling mode
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      write_leaf_count(POS_W'(leaf_plan[p]));
      span = (leaf_plan[p] == 0) ? 1 :
             ((leaf_plan[p] > TREE_LEAVES) ? TREE_LEAVES : leaf_plan[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 64; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 64; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      // after a single-leaf phase, split the root again with a partial insert
      if (p > 0 && leaf_plan[p - 1] <= 1 && span > 1)
        push_item(OP_INSERT, 11'd1, 11'd1, OWNER_W'($urandom()),
                  POS_W'($urandom_range(POS_MAX)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain_results();
        if (span > 1) begin
          push_random_item(span);
        end else if (leaf_plan[p] == 1 && i == PHASE_ITEMS - 20) begin
          // one insert only: a second one would leave the root multiple for good
          push_item(OP_INSERT, 11'd0, 11'd2047, OWNER_W'($urandom()),
                    POS_W'($urandom_range(POS_MAX)));
        end else begin
          push_item(OP_QUERY, POS_W'($urandom_range(POS_MAX)), POS_W'($urandom_range(POS_MAX)),
                    OWNER_W'($urandom()), POS_W'($urandom_range(POS_MAX)));
        end
      end
    end

    quiesce();
    $display("covered %0d inserts and %0d queries over %0d leaf-count settings,",
             n_inserts, n_queries, n_settings);
    $display("with idle, sender-gap, receiver-stall and mixed phases; %0d result beats checked",
             beat_count);
    if (fail_count == 0 && owed_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d result beats still owed", fail_count, owed_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
sv/isuo_pkg.sv
sv/isuo_ifs.sv
sv/isuo_ram.sv
sv/interval_stabbing_unique_owner_core.sv
tb/isuo_owner_checker.sv
tb/interval_stabbing_unique_owner_core_test.sv
